// ----- src/kmp_pkg.sv -----
// Shared types and constants for the KMP substring search core.
// Holds the transaction payload structs, opcodes and controller/datapath links.
// No dependencies.
`default_nettype none

package kmp_pkg;

    localparam int LEN_W  = 7;
    localparam int FAIL_W = 6;
    localparam int OFF_W  = 32;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;
    localparam logic [1:0] OP_NEW  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] pattern_index;
        logic [7:0] data_byte;
        logic       last_text;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] match_position;
        logic [LEN_W-1:0] matched_so_far;
        logic             search_done;
    } t_result;

    typedef struct packed {
        logic take;
        logic seed;
        logic fall;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic load_run;
        logic text_run;
        logic idx_zero;
        logic scan_end;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/kmp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone, no package dependency.
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/kmp_ctrl.sv -----
// Sequencer for the KMP core: accepts transactions and steps the failure-link scan.
// Depends on kmp_pkg for the command and status structs.
`default_nettype none

module kmp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    output kmp_pkg::t_dp_cmd      o_cmd,
    input  wire kmp_pkg::t_dp_sts i_sts
);

    import kmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INIT = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.load_run) begin
                        n_state = S_INIT;
                    end else if (i_sts.text_run) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INIT: begin
                if (i_sts.idx_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.fall = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- src/kmp_dpath.sv -----
// Datapath for the KMP core: pattern and failure RAMs, match state, result register.
// Depends on kmp_pkg and kmp_ram.
`default_nettype none

module kmp_dpath #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kmp_pkg::t_dp_cmd            i_cmd,
    output kmp_pkg::t_dp_sts                 o_sts,
    input  wire kmp_pkg::t_item              i_item,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [kmp_pkg::LEN_W-1:0]   i_cfg_wr_data,
    output logic                             o_result_valid,
    output kmp_pkg::t_result                 o_result
);

    import kmp_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_match;
    logic [OFF_W-1:0]  r_off;
    logic              r_found;
    logic [OFF_W-1:0]  r_first;
    logic              r_valid;
    t_result           r_result;

    logic [LEN_W-1:0]  r_j;
    logic [7:0]        r_byte;
    logic [5:0]        r_idx;
    logic              r_is_load;
    logic              r_last;

    logic [LEN_W-1:0]  n_match;
    logic [OFF_W-1:0]  n_off;
    logic              n_found;
    logic [OFF_W-1:0]  n_first;
    logic              n_valid;
    t_result           n_result;
    logic [LEN_W-1:0]  n_j;

    logic [7:0]        pat_rd;
    logic [FAIL_W-1:0] fail_rd;
    logic [AW-1:0]     fail_raddr;
    logic              fail_we;

    logic              load_ok;
    logic              text_ok;
    logic              hit;
    logic [LEN_W-1:0]  plen;
    logic [OFF_W-1:0]  plen_m1;
    logic [LEN_W-1:0]  j_start;
    logic [LEN_W-1:0]  j_end;
    logic [LEN_W-1:0]  f_ext;
    logic [LEN_W-1:0]  k_seed;
    logic [LEN_W-1:0]  k_fall;
    logic              done_text;

    assign load_ok = (i_item.opcode == OP_LOAD) && (32'(i_item.pattern_index) < PATTERN_MAX);
    assign text_ok = (i_item.opcode == OP_TEXT) && !r_found;

    assign hit     = (pat_rd == r_byte);
    assign f_ext   = LEN_W'(fail_rd);
    assign k_seed  = (fail_rd >= r_idx) ? '0 : f_ext;
    assign k_fall  = (f_ext < r_j) ? f_ext : '0;
    assign j_end   = (r_is_load && (r_idx == '0)) ? '0 : (hit ? (r_j + LEN_W'(1)) : r_j);

    always_comb begin
        if (r_len == '0) begin
            plen = LEN_W'(1);
        end else if (32'(r_len) > PATTERN_MAX) begin
            plen = LEN_W'(PATTERN_MAX);
        end else begin
            plen = r_len;
        end
    end

    assign plen_m1 = OFF_W'(plen) - OFF_W'(1);
    assign j_start = (r_match >= plen) ? '0 : r_match;

    assign o_sts.load_run = load_ok;
    assign o_sts.text_run = text_ok;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.scan_end = hit || (r_j == '0);

    always_comb begin
        if (i_cmd.take) begin
            n_j = j_start;
        end else if (i_cmd.seed) begin
            n_j = k_seed;
        end else if (i_cmd.fall) begin
            n_j = k_fall;
        end else begin
            n_j = r_j;
        end
    end

    always_comb begin
        if (i_cmd.take && (i_item.opcode == OP_LOAD)) begin
            fail_raddr = AW'(i_item.pattern_index - 6'd1);
        end else begin
            fail_raddr = AW'(n_j - LEN_W'(1));
        end
    end

    assign fail_we = i_cmd.finish && r_is_load;

    always_comb begin
        n_match   = r_match;
        n_off     = r_off;
        n_found   = r_found;
        n_first   = r_first;
        n_valid   = 1'b0;
        done_text = 1'b0;
        if (i_cmd.take) begin
            if (i_item.opcode == OP_NEW) begin
                n_match = '0;
                n_off   = '0;
                n_found = 1'b0;
                n_first = '0;
                n_valid = 1'b1;
            end else if (!(load_ok || text_ok)) begin
                n_valid   = 1'b1;
                done_text = (i_item.opcode == OP_TEXT) && i_item.last_text;
            end
        end
        if (i_cmd.finish) begin
            n_valid = 1'b1;
            if (!r_is_load) begin
                done_text = r_last;
                n_match   = j_end;
                if (j_end == plen) begin
                    n_found = 1'b1;
                    n_first = (r_off < plen_m1) ? '0 : (r_off - plen_m1);
                end
                if (r_off != '1) begin
                    n_off = r_off + OFF_W'(1);
                end
            end
        end
        n_result.found          = n_found;
        n_result.match_position = n_found ? n_first : '0;
        n_result.matched_so_far = n_match;
        n_result.search_done    = n_found || done_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(1);
            r_match <= '0;
            r_off   <= '0;
            r_found <= 1'b0;
            r_first <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            r_match <= n_match;
            r_off   <= n_off;
            r_found <= n_found;
            r_first <= n_first;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        if (i_cmd.take) begin
            r_byte    <= i_item.data_byte;
            r_idx     <= i_item.pattern_index;
            r_is_load <= (i_item.opcode == OP_LOAD);
            r_last    <= i_item.last_text;
        end
        if (n_valid) begin
            r_result <= n_result;
        end
    end

    kmp_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && load_ok),
        .i_waddr (AW'(i_item.pattern_index)),
        .i_wdata (i_item.data_byte),
        .i_raddr (AW'(n_j)),
        .o_rdata (pat_rd)
    );

    kmp_ram #(
        .WIDTH (FAIL_W),
        .DEPTH (PATTERN_MAX)
    ) u_failure_ram (
        .i_clk   (i_clk),
        .i_we    (fail_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (j_end[FAIL_W-1:0]),
        .i_raddr (fail_raddr),
        .o_rdata (fail_rd)
    );

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ----- src/kmp_substring_search_core.sv -----
// Top level of the KMP substring search core: controller plus datapath.
// Depends on kmp_pkg, kmp_ctrl, kmp_dpath (and kmp_ram through the datapath).
//
// A transaction is taken when start is high and busy is low; each one yields
// exactly one result, shown on o_result for a single cycle with o_result_valid,
// and the receiver cannot hold it off. Start-new-search, the unused opcode, text
// after a match and out-of-range loads finish at once: the result appears the
// cycle after acceptance and busy stays low. A text byte is scanned through the
// failure links it follows, and a pattern load at index n > 0 first seeds from
// the failure entry of index n - 1 and then scans; a load at index 0 finishes
// straight from the init state. Each scan step is one registered read of the
// pattern and failure RAMs, and busy stays high until the transaction finishes.
// Configuration writes go straight into the registered pattern length.
`default_nettype none

module kmp_substring_search_core #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire kmp_pkg::t_item            i_item,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [kmp_pkg::LEN_W-1:0] i_cfg_wr_data,
    output logic                           o_result_valid,
    output kmp_pkg::t_result               o_result
);

    import kmp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    kmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    kmp_dpath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_item         (i_item),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

// ----- dv/tb_kmp_substring_search_core.sv -----
// Self-checking testbench for kmp_substring_search_core: directed table, then random search phases.
// Every accepted transaction is predicted and checked in order against the single result it yields.
// Depends on kmp_pkg and the kmp_substring_search_core RTL.
`default_nettype none

module tb_kmp_substring_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kmp_pkg::*;

    localparam int PMAX = 64;
    localparam int ITEM_GOAL = 1150;
    localparam int DIR_ROWS = 26;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic       is_cfg;
        logic [6:0] cfg_val;
        t_item      it;
        logic       typed;
        t_result    res;
    } t_dir_row;

    localparam t_result IDLE_RES  = '0;
    localparam t_result HIT_AT0   = '{1'b1, 32'd0, 7'd1, 1'b1};
    localparam t_result DONE_ONLY = '{1'b0, 32'd0, 7'd0, 1'b1};

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_item            i_item = '0;
    logic             i_cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] i_cfg_wr_data = '0;
    logic             o_result_valid;
    t_result          o_result;

    // search model state
    logic [7:0]  pat_mem [PMAX];
    logic [5:0]  fail_mem [PMAX];
    logic [6:0]  cur_len = '0;
    logic [31:0] txt_off = '0;
    logic        hit = 1'b0;
    logic [31:0] hit_off = '0;
    logic [6:0]  cfg_len = 7'd1;

    t_result status_q [$];
    int      err_cnt = 0;
    int      result_cnt = 0;
    int      item_cnt = 0;
    int      match_cnt = 0;
    int      phase_cnt = 0;
    int      loaded_cnt = 0;
    int      burst_left = 0;
    logic [7:0]  sym_lo = 8'h00;
    int unsigned nsym = 2;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{1'b0, 7'd0, '{OP_NEW,   6'd0,  8'h00, 1'b0}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_SPARE, 6'd63, 8'hFF, 1'b1}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_LOAD,  6'd0,  8'h00, 1'b0}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'h00, 1'b0}, 1'b1, HIT_AT0},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b1}, 1'b1, HIT_AT0},
        '{1'b0, 7'd0, '{OP_NEW,   6'd0,  8'h00, 1'b0}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_LOAD,  6'd0,  8'hFF, 1'b1}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_LOAD,  6'd1,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_LOAD,  6'd2,  8'h00, 1'b0}, 1'b0, IDLE_RES},
        '{1'b1, 7'd3, '0, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_LOAD,  6'd3,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'h00, 1'b1}, 1'b0, IDLE_RES},
        '{1'b1, 7'd0, '0, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_NEW,   6'd0,  8'h00, 1'b0}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'h00, 1'b1}, 1'b1, DONE_ONLY},
        '{1'b1, 7'd3, '0, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_NEW,   6'd0,  8'h00, 1'b0}, 1'b1, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b0}, 1'b0, IDLE_RES},
        '{1'b1, 7'd2, '0, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'h00, 1'b0}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_TEXT,  6'd0,  8'hFF, 1'b1}, 1'b0, IDLE_RES},
        '{1'b0, 7'd0, '{OP_SPARE, 6'd21, 8'h5A, 1'b0}, 1'b0, IDLE_RES}
    };

    kmp_substring_search_core #(
        .PATTERN_MAX(PMAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned eff_len(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > PMAX) return PMAX;
        return v;
    endfunction

    function automatic int unsigned link_back(input int unsigned k);
        int unsigned nk;
        if (k == 0 || k > PMAX) return 0;
        nk = fail_mem[k-1];
        return (nk < k) ? nk : 0;
    endfunction

    function automatic t_result search_step(input t_item it);
        int unsigned idx;
        int unsigned k;
        int unsigned j;
        int unsigned plen;
        t_result     r;
        idx = it.pattern_index;
        item_cnt++;
        case (it.opcode)
            OP_LOAD: begin
                pat_mem[idx] = it.data_byte;
                k = 0;
                if (idx > 0) begin
                    k = fail_mem[idx-1];
                    if (k >= idx) k = 0;
                    while (k > 0 && pat_mem[k] != it.data_byte) k = link_back(k);
                    if (pat_mem[k] == it.data_byte) k++;
                end
                fail_mem[idx] = 6'(k);
            end
            OP_TEXT: begin
                if (!hit) begin
                    plen = eff_len(cfg_len);
                    j = cur_len;
                    if (j >= plen) j = 0;
                    while (j > 0 && pat_mem[j] != it.data_byte) j = link_back(j);
                    if (pat_mem[j] == it.data_byte) j++;
                    if (j == plen) begin
                        hit = 1'b1;
                        match_cnt++;
                        hit_off = (64'(txt_off) + 1 < plen) ? 32'd0 : txt_off - 32'(plen - 1);
                    end
                    if (txt_off != 32'hFFFF_FFFF) txt_off++;
                    cur_len = 7'(j);
                end
            end
            OP_NEW: begin
                cur_len = '0;
                txt_off = '0;
                hit = 1'b0;
                hit_off = '0;
            end
            default: ;
        endcase
        r.found = hit;
        r.match_position = hit ? hit_off : 32'd0;
        r.matched_so_far = cur_len;
        r.search_done = hit | ((it.opcode == OP_TEXT) & it.last_text);
        return r;
    endfunction

    function automatic t_item mk_item(input logic [1:0] op, input logic [5:0] idx,
                                      input logic [7:0] b, input logic last);
        t_item it;
        it.opcode = op;
        it.pattern_index = idx;
        it.data_byte = b;
        it.last_text = last;
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 24) == 0) return 8'($urandom);
        return sym_lo + 8'($urandom_range(0, nsym - 1));
    endfunction

    task automatic send(input t_item it, input logic typed, input t_result typed_res);
        t_result r;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        r = search_step(it);
        if (it.opcode == OP_LOAD && int'(it.pattern_index) == loaded_cnt) loaded_cnt++;
        if (typed) r = typed_res;
        status_q = {status_q, r};
    endtask

    task automatic set_length(input logic [6:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_len = v;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            result_cnt++;
            if (status_q.size() == 0) begin
                err_cnt++;
                if (err_cnt < 50)
                    $display("%0t: unexpected result %p", $time, o_result);
            end else begin
                if (o_result !== status_q[0]) begin
                    err_cnt++;
                    if (err_cnt < 50)
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, status_q[0], o_result);
                end
                void'(status_q.pop_front());
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned r;
        int unsigned plen_pat;
        int unsigned tgt;
        int unsigned eff;
        int unsigned tlen;
        int unsigned total;
        int unsigned plant;
        int unsigned i;
        logic        planting;
        logic        reload;
        logic [6:0]  v;
        logic [7:0]  b;
        logic        last;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            if (dir_tab[n].is_cfg)
                set_length(dir_tab[n].cfg_val);
            else
                send(dir_tab[n].it, dir_tab[n].typed, dir_tab[n].res);
        end

        while (item_cnt < ITEM_GOAL) begin
            phase_cnt++;
            r = $urandom_range(0, 99);
            plen_pat = (r < 80) ? $urandom_range(1, 6) : (r < 92) ? $urandom_range(7, 20) : PMAX;
            reload = (phase_cnt == 1) || ($urandom_range(0, 3) != 0);
            if (reload) begin
                sym_lo = 8'($urandom_range(0, 253));
                nsym = $urandom_range(2, 3);
                for (i = 0; i < plen_pat; i++)
                    send(mk_item(OP_LOAD, 6'(i), pick_byte(), 1'($urandom)), 1'b0, IDLE_RES);
                tgt = plen_pat;
            end else begin
                tgt = $urandom_range(1, loaded_cnt);
            end

            r = $urandom_range(0, 99);
            if (r < 10)
                v = 7'd0;
            else if (loaded_cnt == PMAX && (r < 20 || tgt == PMAX))
                v = 7'($urandom_range(PMAX, 127));
            else
                v = 7'(tgt);
            set_length(v);
            eff = eff_len(v);

            if ($urandom_range(0, 99) < 85)
                send(mk_item(OP_NEW, 6'($urandom), 8'($urandom), 1'($urandom)), 1'b0, IDLE_RES);

            tlen = $urandom_range(3, 24);
            planting = ($urandom_range(0, 99) < 60);
            plant = $urandom_range(0, tlen - 1);
            total = (planting && plant + eff > tlen) ? plant + eff : tlen;
            for (i = 0; i < total; i++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send(mk_item(OP_SPARE, 6'($urandom), 8'($urandom), 1'($urandom)),
                         1'b0, IDLE_RES);
                end else if (r < 7) begin
                    n = $urandom_range(0, (loaded_cnt < PMAX) ? loaded_cnt : PMAX - 1);
                    send(mk_item(OP_LOAD, 6'(n), pick_byte(), 1'($urandom)), 1'b0, IDLE_RES);
                end
                if (planting && i >= plant && i < plant + eff)
                    b = pat_mem[i - plant];
                else
                    b = pick_byte();
                last = (i == total - 1) || ($urandom_range(0, 19) == 0);
                send(mk_item(OP_TEXT, 6'($urandom), b, last), 1'b0, IDLE_RES);
            end
        end

        start <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Ran %0d transactions (%0d results checked) over %0d search phases",
                 item_cnt, result_cnt, phase_cnt);
        $display("Predicted %0d first matches, %0d errors", match_cnt, err_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
